/* rtl/pht_pkg.sv */
// package: types, codes and constants shared by the periodic hook table
package pht_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int SLOT_W        = 4;
   localparam int TIME_W        = 64;
   localparam int MAX_SLOTS     = 1 << SLOT_W;

   typedef enum logic [1:0] {
      CMD_REGISTER   = 2'd0,
      CMD_ENABLE     = 2'd1,
      CMD_UNREGISTER = 2'd2,
      CMD_FIRE       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_NOALLOC = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MODE_UNUSED   = 2'd0,
      MODE_ALLOCED  = 2'd1,
      MODE_DISABLED = 2'd2,
      MODE_ENABLED  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] out_slot;
      status_type        status;
      logic              due;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic scan_step;
      logic flush;
   } ctrl_type;

   typedef struct packed {
      logic req_fire;
      logic scan_last;
   } stat_type;

endpackage

/* rtl/pht_ctrl.sv */
// controller state machine for the periodic hook table
module pht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pht_pkg::stat_type stat,
   output pht_pkg::ctrl_type ctrl,
   output logic              busy
);
   import pht_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = stat.req_fire ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC:  state_in = ST_IDLE;
         ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FLUSH;
         ST_FLUSH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start;
         end
         ST_EXEC:  ctrl.exec = 1'b1;
         ST_SCAN:  ctrl.scan_step = 1'b1;
         ST_DRAIN: ctrl = '0;
         ST_FLUSH: ctrl.flush = 1'b1;
         default:  ctrl = '0;
      endcase
   end

endmodule

/* rtl/pht_datapath.sv */
// datapath: slot modes, period and start-time memories, scan compare and result register
module pht_datapath #(
   parameter int NUM_SLOTS = pht_pkg::NUM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  pht_pkg::req_type  req_item,
   input  pht_pkg::ctrl_type ctrl,
   output pht_pkg::stat_type stat,
   output logic              rsp_strobe,
   output pht_pkg::rsp_type  rsp_item
);
   import pht_pkg::*;

   localparam int ADDR_SLOTS = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
   localparam int IW         = (ADDR_SLOTS > 1) ? $clog2(ADDR_SLOTS) : 1;

   req_type           req_ff;
   mode_type          mode_ff [ADDR_SLOTS];
   mode_type          mode_in [ADDR_SLOTS];
   logic [TIME_W-1:0] period_mem [ADDR_SLOTS];
   logic [TIME_W-1:0] start_mem [ADDR_SLOTS];

   logic [IW-1:0]     cnt_ff, cnt_in;
   logic              cmp_vld_ff;
   logic [IW-1:0]     cmp_idx_ff;
   logic [TIME_W-1:0] rd_period_ff;
   logic [TIME_W-1:0] rd_start_ff;
   logic              pend_vld_ff, pend_vld_in;
   logic [IW-1:0]     pend_idx_ff, pend_idx_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic              free_found;
   logic [IW-1:0]     free_idx;
   logic              slot_alloc;
   logic [IW-1:0]     slot_idx;
   logic [TIME_W:0]   due_sum;
   logic              hit;
   logic              wr_en;
   logic              wr_period;
   logic [IW-1:0]     wr_addr;
   logic [TIME_W-1:0] wr_start;

   // lowest unused slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = ADDR_SLOTS - 1; i >= 0; i--) begin
         if (mode_ff[i] == MODE_UNUSED) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   assign slot_idx   = req_ff.slot[IW-1:0];
   assign slot_alloc = ({1'b0, req_ff.slot} < (SLOT_W + 1)'(ADDR_SLOTS)) &&
                       (mode_ff[slot_idx] != MODE_UNUSED);

   // sum kept one bit wider so an overflowing sum is never due
   assign due_sum = {1'b0, rd_start_ff} + {1'b0, rd_period_ff};
   assign hit     = cmp_vld_ff && (mode_ff[cmp_idx_ff] == MODE_ENABLED) &&
                    ({1'b0, req_ff.now} >= due_sum);

   assign stat.req_fire  = (req_item.cmd == CMD_FIRE);
   assign stat.scan_last = (cnt_ff == IW'(ADDR_SLOTS - 1));

   always_comb begin
      mode_in       = mode_ff;
      cnt_in        = cnt_ff;
      pend_vld_in   = pend_vld_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_period     = 1'b0;
      wr_addr       = cmp_idx_ff;
      wr_start      = req_ff.now;

      if (ctrl.load) begin
         cnt_in      = '0;
         pend_vld_in = 1'b0;
      end

      if (ctrl.scan_step) begin
         cnt_in = cnt_ff + IW'(1);
      end

      if (ctrl.exec) begin
         rsp_strobe_in   = 1'b1;
         rsp_in.out_slot = req_ff.slot;
         rsp_in.status   = STATUS_OK;
         rsp_in.due      = 1'b0;
         rsp_in.last     = 1'b1;
         case (req_ff.cmd)
            CMD_REGISTER: begin
               if (free_found) begin
                  mode_in[free_idx] = MODE_DISABLED;
                  wr_en             = 1'b1;
                  wr_period         = 1'b1;
                  wr_addr           = free_idx;
                  wr_start          = '0;
                  rsp_in.out_slot   = SLOT_W'(free_idx);
               end else begin
                  rsp_in.out_slot = '0;
                  rsp_in.status   = STATUS_FULL;
               end
            end
            CMD_ENABLE: begin
               if (slot_alloc) begin
                  mode_in[slot_idx] = MODE_ENABLED;
               end else begin
                  rsp_in.status = STATUS_NOALLOC;
               end
            end
            CMD_UNREGISTER: begin
               if (slot_alloc) begin
                  mode_in[slot_idx] = MODE_UNUSED;
               end else begin
                  rsp_in.status = STATUS_NOALLOC;
               end
            end
            default: rsp_in.status = STATUS_OK;
         endcase
      end

      // a due slot is held until the next one shows whether it is the final transfer
      if (hit) begin
         wr_en       = 1'b1;
         pend_vld_in = 1'b1;
         pend_idx_in = cmp_idx_ff;
         if (pend_vld_ff) begin
            rsp_strobe_in   = 1'b1;
            rsp_in.out_slot = SLOT_W'(pend_idx_ff);
            rsp_in.status   = STATUS_OK;
            rsp_in.due      = 1'b1;
            rsp_in.last     = 1'b0;
         end
      end

      if (ctrl.flush) begin
         rsp_strobe_in   = 1'b1;
         rsp_in.out_slot = pend_vld_ff ? SLOT_W'(pend_idx_ff) : '0;
         rsp_in.status   = STATUS_OK;
         rsp_in.due      = pend_vld_ff;
         rsp_in.last     = 1'b1;
         pend_vld_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ADDR_SLOTS; i++) begin
            mode_ff[i] <= MODE_UNUSED;
         end
         cmp_vld_ff    <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         cmp_vld_ff    <= ctrl.scan_step;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff <= req_item;
      end
      cnt_ff      <= cnt_in;
      cmp_idx_ff  <= cnt_ff;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   // slot memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_addr] <= wr_start;
      end
      if (wr_en && wr_period) begin
         period_mem[wr_addr] <= req_ff.period;
      end
      rd_period_ff <= period_mem[cnt_ff];
      rd_start_ff  <= start_mem[cnt_ff];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

/* rtl/periodic_hook_table.sv */
// top level of the periodic hook table: controller and datapath
//
// A command is taken when start is high and busy is low. Register, enable and
// unregister give one result in the same cycle that busy falls. Fire scans
// the slot table one slot per cycle through the period and start memories,
// and keeps busy high through the scan and the drain and flush states after
// it. Its results come out during the scan and at its end, each on rsp_item
// for one cycle with rsp_strobe high; the final transfer has last set.
// Results cannot be held off, so the receiver must take every strobe.
module periodic_hook_table #(
   parameter int NUM_SLOTS = pht_pkg::NUM_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pht_pkg::req_type req_item,
   output logic             rsp_strobe,
   output pht_pkg::rsp_type rsp_item
);
   import pht_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   pht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   pht_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .ctrl       (ctrl),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

/* test/tb.sv */
// testbench for the periodic hook table: predicting scoreboard, command driver and result monitor
`timescale 1ns / 100ps

import pht_pkg::*;

class hook_ledger;
   localparam int HOOK_SLOTS = (NUM_SLOTS_DEF < MAX_SLOTS) ? NUM_SLOTS_DEF : MAX_SLOTS;

   mode_type          mode [MAX_SLOTS];
   logic [TIME_W-1:0] period_of [MAX_SLOTS];
   logic [TIME_W-1:0] started_at [MAX_SLOTS];
   rsp_type           pending_results [$];

   int errors;
   int results_checked;
   int cmd_count [4];
   int due_results;
   int most_due;
   int full_count;
   int noalloc_count;
   int overflow_skips;

   function new();
      int i;
      for (i = 0; i < MAX_SLOTS; i++) begin
         mode[i] = MODE_UNUSED;
         period_of[i] = '0;
         started_at[i] = '0;
      end
      for (i = 0; i < 4; i++) cmd_count[i] = 0;
      errors = 0;
      results_checked = 0;
      due_results = 0;
      most_due = 0;
      full_count = 0;
      noalloc_count = 0;
      overflow_skips = 0;
   endfunction

   function int pending();
      return pending_results.size();
   endfunction

   function logic [SLOT_W-1:0] pick_allocated();
      logic [SLOT_W-1:0] taken [$];
      int i;
      for (i = 0; i < HOOK_SLOTS; i++)
         if (mode[i] != MODE_UNUSED) taken.push_back(SLOT_W'(i));
      if (taken.size() == 0) return SLOT_W'($urandom);
      return taken[$urandom_range(taken.size() - 1)];
   endfunction

   // work out the results of one accepted command and update the table
   function void log_command(req_type r);
      rsp_type           res;
      logic [TIME_W:0]   deadline;
      int                i;
      int                n;
      res = '{out_slot: '0, status: STATUS_OK, due: 1'b0, last: 1'b1};
      n = 0;
      cmd_count[r.cmd]++;
      case (r.cmd)
         CMD_REGISTER: begin
            res.status = STATUS_FULL;
            for (i = 0; i < HOOK_SLOTS; i++) begin
               if (mode[i] == MODE_UNUSED) begin
                  mode[i] = MODE_DISABLED;
                  period_of[i] = r.period;
                  started_at[i] = '0;
                  res.out_slot = SLOT_W'(i);
                  res.status = STATUS_OK;
                  break;
               end
            end
            if (res.status == STATUS_FULL) full_count++;
            pending_results.push_back(res);
         end
         CMD_ENABLE, CMD_UNREGISTER: begin
            res.out_slot = r.slot;
            if (r.slot >= HOOK_SLOTS || mode[r.slot] == MODE_UNUSED) begin
               res.status = STATUS_NOALLOC;
               noalloc_count++;
            end else begin
               mode[r.slot] = (r.cmd == CMD_ENABLE) ? MODE_ENABLED : MODE_UNUSED;
            end
            pending_results.push_back(res);
         end
         default: begin
            for (i = 0; i < HOOK_SLOTS; i++) begin
               if (mode[i] == MODE_ENABLED) begin
                  deadline = {1'b0, started_at[i]} + {1'b0, period_of[i]};
                  if (deadline[TIME_W]) begin
                     overflow_skips++;
                  end else if ({1'b0, r.now} >= deadline) begin
                     pending_results.push_back('{out_slot: SLOT_W'(i), status: STATUS_OK,
                                                 due: 1'b1, last: 1'b0});
                     started_at[i] = r.now;
                     n++;
                  end
               end
            end
            if (n == 0) begin
               pending_results.push_back(res);
            end else begin
               pending_results[pending_results.size() - 1].last = 1'b1;
               due_results += n;
               if (n > most_due) most_due = n;
            end
         end
      endcase
   endfunction

   // compare one result transfer against the oldest prediction
   function void match_result(rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result: slot %0d status %0d due %0d last %0d",
                  $time, got.out_slot, got.status, got.due, got.last);
         errors++;
         return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (got.out_slot !== want.out_slot || got.status !== want.status ||
          got.due !== want.due || got.last !== want.last) begin
         $display("%0t: result mismatch: expected slot %0d status %0d due %0d last %0d",
                  $time, want.out_slot, want.status, want.due, want.last);
         $display("%0t:                  actual   slot %0d status %0d due %0d last %0d",
                  $time, got.out_slot, got.status, got.due, got.last);
         errors++;
      end
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 300;
   localparam int HOOK_SLOTS   = (NUM_SLOTS_DEF < MAX_SLOTS) ? NUM_SLOTS_DEF : MAX_SLOTS;
   localparam int REQ_BITS     = $bits(req_type);
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   hook_ledger books = new();
   int         cycle_count = 0;

   periodic_hook_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding", $time, books.pending());
         $display("periodic_hook_table regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) books.match_result(rsp_item);
   end

   // hold start high until the block takes the command
   task automatic send_item(req_type r);
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      books.log_command(r);
   endtask

   task automatic issue(cmd_type c, logic [SLOT_W-1:0] s, logic [TIME_W-1:0] p,
                        logic [TIME_W-1:0] t);
      req_type r;
      r.cmd = c;
      r.slot = s;
      r.period = p;
      r.now = t;
      send_item(r);
   endtask

   task automatic idle_for(int n);
      start <= 1'b0;
      req_item <= REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
      repeat (n) @(posedge clock);
   endtask

   initial begin
      req_type           r;
      logic [TIME_W-1:0] wall;
      int                burst_left;
      int                roll;
      int                k;

      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, bad slots, fill to full, extreme periods and times
      issue(CMD_FIRE, 4'd0, '0, '0);
      issue(CMD_ENABLE, 4'd15, TIME_MAX, TIME_MAX);
      issue(CMD_UNREGISTER, 4'd0, '0, '0);
      issue(CMD_REGISTER, 4'd15, '0, TIME_MAX);
      issue(CMD_REGISTER, 4'd0, TIME_MAX, '0);
      for (k = 2; k < HOOK_SLOTS; k++)
         issue(CMD_REGISTER, 4'($urandom), 64'($urandom_range(30)), {$urandom, $urandom});
      issue(CMD_REGISTER, 4'd0, TIME_MAX, '0);
      issue(CMD_ENABLE, 4'd0, '0, '0);
      issue(CMD_ENABLE, 4'd1, '0, '0);
      issue(CMD_ENABLE, 4'd0, TIME_MAX, TIME_MAX);
      issue(CMD_FIRE, 4'd15, TIME_MAX, '0);
      issue(CMD_FIRE, 4'd0, '0, TIME_MAX);
      issue(CMD_FIRE, 4'd0, '0, TIME_MAX);
      issue(CMD_UNREGISTER, 4'd1, '0, '0);
      issue(CMD_UNREGISTER, 4'd1, '0, '0);

      // random: bursts of commands against a slowly advancing fire time
      wall = '0;
      burst_left = 0;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (burst_left == 0) begin
            if ($urandom_range(3) != 0) idle_for($urandom_range(1, 12));
            burst_left = ($urandom_range(5) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
         end
         burst_left--;
         roll = $urandom_range(99);
         r.cmd = (roll < 28) ? CMD_REGISTER :
                 (roll < 53) ? CMD_ENABLE :
                 (roll < 70) ? CMD_UNREGISTER : CMD_FIRE;
         r.slot = ($urandom_range(7) == 0) ? 4'($urandom) : books.pick_allocated();
         r.period = ($urandom_range(4) == 0) ? {$urandom, $urandom}
                                             : 64'($urandom_range(60));
         r.now = {$urandom, $urandom};
         if (r.cmd == CMD_FIRE) begin
            roll = $urandom_range(39);
            if (roll == 0) wall = TIME_MAX;
            else if (roll < 3) wall = {$urandom, $urandom};
            else wall = wall + 64'($urandom_range(40));
            r.now = wall;
         end
         send_item(r);
      end
      idle_for(0);

      while (books.pending() != 0) @(posedge clock);
      repeat (25) @(posedge clock);

      $display("covered %0d register, %0d enable, %0d unregister and %0d fire transfers",
               books.cmd_count[CMD_REGISTER], books.cmd_count[CMD_ENABLE],
               books.cmd_count[CMD_UNREGISTER], books.cmd_count[CMD_FIRE]);
      $display("checked %0d results: %0d due (up to %0d per fire), %0d full, %0d unallocated",
               books.results_checked, books.due_results, books.most_due,
               books.full_count, books.noalloc_count);
      if (books.errors == 0)
         $display("periodic_hook_table regression: pass");
      else
         $display("periodic_hook_table regression: fail");
      $finish;
   end
endmodule

/* filelist.f */
rtl/pht_pkg.sv
rtl/pht_ctrl.sv
rtl/pht_datapath.sv
rtl/periodic_hook_table.sv
test/tb.sv
